### design/cczoom_pkg.sv
// Shared widths, register indexes and the dimension clamp of the
// center-crop 2x bilinear zoom. No dependencies.
package cczoom_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int MIN_DIM     = 4;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 10;
    localparam int CFG_W       = 12;
    localparam int CFG_INDEX_W = 1;

    // Column and row counters hold positions up to the largest dimension minus one.
    localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CNT_W       = $clog2(MAX_DIM);
    // Geometry values must hold both a counter and the clamped dimension itself.
    localparam int GEO_W       = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;

    // Line store covers crop columns c0 .. c0 + W/2.
    localparam int STORE_DEPTH = MAX_WIDTH / 2 + 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    localparam logic [GEO_W-1:0] WIDTH_RESET  = GEO_W'(1920);
    localparam logic [GEO_W-1:0] HEIGHT_RESET = GEO_W'(1080);

    // Clamp a written dimension into [MIN_DIM, hi].
    function automatic logic [GEO_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        logic [GEO_W-1:0] ext;
        logic [GEO_W-1:0] res;
        ext = GEO_W'(v);
        if (ext < GEO_W'(MIN_DIM))
        begin
            res = GEO_W'(MIN_DIM);
        end
        else if (int'(ext) > hi)
        begin
            res = GEO_W'(hi);
        end
        else
        begin
            res = ext;
        end
        return res;
    endfunction

endpackage

### design/center_crop_bilinear_zoom_2x.sv
// Center-crop 2x bilinear zoom: top level with counters, line store and quad math.
// Depends on cczoom_pkg.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------------
//  pixel in  | pixel_valid / pixel_stall  | pixel, frame_start
//  quad out  | quad_valid / quad_stall    | quad_x, quad_y, top_left, top_right,
//            |                            | bottom_left, bottom_right, frame_last
//  config    | cfg_write_enable           | cfg_index, cfg_wdata
//
// One pixel transaction per clock while pixel_stall is low. An accepted pixel enters the
// stage-1 register (line-store read/write on accept); its quad moves on to the quad
// register when that is free. Throughput is set by the single line-store port, used at
// most once per pixel. pixel_stall rises only while stage 1 holds a quad and the quad
// register is full and stalled. Reset clears counters, valid flags and the neighbor
// pixels; the line store has no reset and needs no clearing pass.
module center_crop_bilinear_zoom_2x
    import cczoom_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,

    input  logic                   pixel_valid,
    output logic                   pixel_stall,
    input  logic [PIX_W-1:0]       pixel,
    input  logic                   frame_start,

    output logic                   quad_valid,
    input  logic                   quad_stall,
    output logic [COORD_W-1:0]     quad_x,
    output logic [COORD_W-1:0]     quad_y,
    output logic [PIX_W-1:0]       top_left,
    output logic [PIX_W-1:0]       top_right,
    output logic [PIX_W-1:0]       bottom_left,
    output logic [PIX_W-1:0]       bottom_right,
    output logic                   frame_last
);

    // ------------------------------------------------------------------
    // Geometry registers: hold the clamped width and height.
    // ------------------------------------------------------------------
    logic [GEO_W-1:0] width_reg;
    logic [GEO_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= clamp_dim(cfg_wdata, MAX_WIDTH);
                REG_FRAME_HEIGHT: height_reg <= clamp_dim(cfg_wdata, MAX_HEIGHT);
            endcase
        end
    end

    // Crop origin and size, all by shifts.
    logic [GEO_W-1:0] crop_c0;
    logic [GEO_W-1:0] crop_r0;
    logic [GEO_W-1:0] crop_cw;
    logic [GEO_W-1:0] crop_ch;

    assign crop_c0 = width_reg  >> 2;
    assign crop_r0 = height_reg >> 2;
    assign crop_cw = width_reg  >> 1;
    assign crop_ch = height_reg >> 1;

    // ------------------------------------------------------------------
    // Handshake control.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_emit_reg;
    logic quad_valid_reg;
    logic out_free;
    logic s1_advance;
    logic accept;

    // Quad register can take a new quad when empty or when its quad leaves now.
    assign out_free    = !quad_valid_reg || !quad_stall;
    // A stage-1 item without a quad drops out regardless of the output side.
    assign s1_advance  = s1_valid_reg && (!s1_emit_reg || out_free);
    assign pixel_stall = s1_valid_reg && s1_emit_reg && !out_free;
    assign accept      = pixel_valid && !pixel_stall;

    // ------------------------------------------------------------------
    // Stage 0: position of the incoming pixel and what it touches.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_next;
    logic [GEO_W-1:0] cur_c;
    logic [GEO_W-1:0] cur_r;
    logic [GEO_W-1:0] rel_c;
    logic [GEO_W-1:0] rel_r;
    logic [GEO_W-1:0] quad_xf;
    logic [GEO_W-1:0] quad_yf;
    logic             store_hit;
    logic             emit;
    logic             last;
    logic [ADDR_W-1:0] store_addr;

    // frame_start restarts the position at row 0, column 0.
    assign cur_c = frame_start ? '0 : GEO_W'(col_reg);
    assign cur_r = frame_start ? '0 : GEO_W'(row_reg);

    assign rel_c   = cur_c - crop_c0;
    assign rel_r   = cur_r - crop_r0;
    assign quad_xf = rel_c - GEO_W'(1);
    assign quad_yf = rel_r - GEO_W'(1);

    // Line store holds the previous row over crop columns c0 .. c0+W/2.
    assign store_hit  = (cur_c >= crop_c0) && (rel_c <= crop_cw);
    assign store_addr = rel_c[ADDR_W-1:0];

    // A quad closes when this pixel is the bottom-right of a neighborhood inside the crop.
    assign emit = (cur_r > crop_r0) && (cur_r <= crop_r0 + crop_ch)
               && (cur_c > crop_c0) && (cur_c <= crop_c0 + crop_cw);
    assign last = (quad_yf == crop_ch - GEO_W'(1)) && (quad_xf == crop_cw - GEO_W'(1));

    always_comb
    begin
        if (cur_c >= width_reg - GEO_W'(1))
        begin
            col_next = '0;
            if (cur_r >= height_reg - GEO_W'(1))
            begin
                row_next = '0;
            end
            else
            begin
                row_next = CNT_W'(cur_r + GEO_W'(1));
            end
        end
        else
        begin
            col_next = CNT_W'(cur_c + GEO_W'(1));
            row_next = CNT_W'(cur_r);
        end
    end

    // ------------------------------------------------------------------
    // Line store: read-first, one access per accepted pixel inside the stored columns.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] line_store [0:STORE_DEPTH-1];
    logic [PIX_W-1:0] store_rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept && store_hit)
        begin
            store_rd_reg           <= line_store[store_addr];
            line_store[store_addr] <= pixel;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers and neighbor pixels.
    // ------------------------------------------------------------------
    logic               s1_hit_reg;
    logic               s1_last_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    logic [PIX_W-1:0]   s1_d_reg;
    logic [PIX_W-1:0]   s1_l_reg;
    logic [PIX_W-1:0]   s1_a_reg;
    logic [PIX_W-1:0]   left_reg;
    logic [PIX_W-1:0]   hold_b_reg;
    logic [PIX_W-1:0]   s1_b;
    logic               s1_valid_next;

    // Pixel above the current one; zero where the column is outside the store.
    assign s1_b = s1_hit_reg ? store_rd_reg : '0;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_hit_reg   <= 1'b0;
            left_reg     <= '0;
            hold_b_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            // Keep the last above-pixel around once its item has left stage 1.
            if (s1_valid_reg)
            begin
                hold_b_reg <= s1_b;
            end
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                s1_emit_reg <= emit;
                s1_hit_reg  <= store_hit;
                left_reg    <= pixel;
            end
        end
    end

    // Stage 1 payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= quad_xf[COORD_W-1:0];
            s1_y_reg    <= quad_yf[COORD_W-1:0];
            s1_last_reg <= last;
            s1_d_reg    <= pixel;
            s1_l_reg    <= left_reg;
            // Above-left is the above pixel of the previous transaction.
            s1_a_reg    <= s1_valid_reg ? s1_b : hold_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // Quad math and output register.
    // ------------------------------------------------------------------
    logic [PIX_W:0]   sum_ab;
    logic [PIX_W:0]   sum_al;
    logic [PIX_W+1:0] sum_all;
    logic [PIX_W-1:0] tr_val;
    logic [PIX_W-1:0] bl_val;
    logic [PIX_W-1:0] br_val;

    assign sum_ab  = {1'b0, s1_a_reg} + {1'b0, s1_b};
    assign sum_al  = {1'b0, s1_a_reg} + {1'b0, s1_l_reg};
    assign sum_all = {1'b0, sum_ab} + {2'b00, s1_l_reg} + {2'b00, s1_d_reg};
    assign tr_val  = sum_ab[PIX_W:1];
    assign bl_val  = sum_al[PIX_W:1];
    assign br_val  = sum_all[PIX_W+1:2];

    logic               quad_load;
    logic [COORD_W-1:0] quad_x_reg;
    logic [COORD_W-1:0] quad_y_reg;
    logic [PIX_W-1:0]   top_left_reg;
    logic [PIX_W-1:0]   top_right_reg;
    logic [PIX_W-1:0]   bottom_left_reg;
    logic [PIX_W-1:0]   bottom_right_reg;
    logic               frame_last_reg;

    assign quad_load = s1_valid_reg && s1_emit_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            quad_valid_reg <= quad_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (quad_load)
        begin
            quad_x_reg       <= s1_x_reg;
            quad_y_reg       <= s1_y_reg;
            top_left_reg     <= s1_a_reg;
            top_right_reg    <= tr_val;
            bottom_left_reg  <= bl_val;
            bottom_right_reg <= br_val;
            frame_last_reg   <= s1_last_reg;
        end
    end

    assign quad_valid   = quad_valid_reg;
    assign quad_x       = quad_x_reg;
    assign quad_y       = quad_y_reg;
    assign top_left     = top_left_reg;
    assign top_right    = top_right_reg;
    assign bottom_left  = bottom_left_reg;
    assign bottom_right = bottom_right_reg;
    assign frame_last   = frame_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input backs up only behind a stalled, full quad register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (quad_valid && quad_stall))
        else $error("pixel_stall without a stalled quad");

    // A pending quad in stage 1 reaches the output when the output side is free.
    a_quad_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit_reg && out_free) |=> quad_valid_reg)
        else $error("stage-1 quad lost");

    // Frame start puts the next pixel at row 0, column 1.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_start) |=> (col_reg == CNT_W'(1) && row_reg == '0))
        else $error("counters not restarted on frame start");

endmodule

### tb/sv/center_crop_bilinear_zoom_2x_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for center_crop_bilinear_zoom_2x: streams pixel transactions,
// predicts each quad in step with the stream and compares every field of every quad.
// Depends on cczoom_pkg and the center_crop_bilinear_zoom_2x RTL.
module center_crop_bilinear_zoom_2x_test;
    import cczoom_pkg::*;

    // Stop the random part after this many pixel transactions.
    localparam int RANDOM_ITEMS = 1600;
    // Keep both sides busy for the last stretch of the random part.
    localparam int CALM_TAIL    = 300;
    // Margin after the last expected quad, so the pipeline can empty.
    localparam int DRAIN_CYCLES = 8;
    // Receiver hold-off that fills the pipeline and backs up the input.
    localparam int LONG_HOLD    = 80;
    // Cycles without any transaction on either channel before giving up.
    localparam int QUIET_LIMIT  = 2000;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   tl;
        logic [PIX_W-1:0]   tr;
        logic [PIX_W-1:0]   bl;
        logic [PIX_W-1:0]   br;
        logic               last;
    } zoom_quad_t;

    // One row of the directed table. With typed set, has_quad and quad give the
    // answer directly; otherwise the predictor supplies it.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             start;
        logic             typed;
        logic             has_quad;
        zoom_quad_t       quad;
    } directed_row_t;

    localparam zoom_quad_t NO_QUAD = '0;

    logic               clk              = 1'b0;
    logic               rst_n            = 1'b0;
    logic               cfg_write_enable = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]   cfg_wdata        = '0;
    logic               pixel_valid      = 1'b0;
    logic               pixel_stall;
    logic [PIX_W-1:0]   pixel            = '0;
    logic               frame_start      = 1'b0;
    logic               quad_valid;
    logic               quad_stall       = 1'b0;
    logic [COORD_W-1:0] quad_x;
    logic [COORD_W-1:0] quad_y;
    logic [PIX_W-1:0]   top_left;
    logic [PIX_W-1:0]   top_right;
    logic [PIX_W-1:0]   bottom_left;
    logic [PIX_W-1:0]   bottom_right;
    logic               frame_last;

    // Predictor copy of the registers and of the block's state.
    logic [CFG_W-1:0]   width_reg      = CFG_W'(WIDTH_RESET);
    logic [CFG_W-1:0]   height_reg     = CFG_W'(HEIGHT_RESET);
    logic [CNT_W-1:0]   col_pos        = '0;
    logic [CNT_W-1:0]   row_pos        = '0;
    logic [PIX_W-1:0]   left_pix       = '0;
    logic [PIX_W-1:0]   upper_left_pix = '0;
    logic [PIX_W-1:0]   prior_row [0:STORE_DEPTH-1];

    zoom_quad_t         pending_quads [$];
    directed_row_t      directed_rows [0:23];

    int                 error_count  = 0;
    int                 quiet_cycles = 0;
    int                 tx_idle_pct  = 0;
    int                 rx_idle_pct  = 0;
    int                 stall_left   = 0;
    logic               hold_token   = 1'b0;
    logic               hold_seen    = 1'b0;

    center_crop_bilinear_zoom_2x dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .pixel_valid      (pixel_valid),
        .pixel_stall      (pixel_stall),
        .pixel            (pixel),
        .frame_start      (frame_start),
        .quad_valid       (quad_valid),
        .quad_stall       (quad_stall),
        .quad_x           (quad_x),
        .quad_y           (quad_y),
        .top_left         (top_left),
        .top_right        (top_right),
        .bottom_left      (bottom_left),
        .bottom_right     (bottom_right),
        .frame_last       (frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp a register value into the usable range of a frame side.
    function automatic int clamp_side(input logic [CFG_W-1:0] v, input int hi);
        if (v < MIN_DIM)
        begin
            return MIN_DIM;
        end
        if (v > hi)
        begin
            return hi;
        end
        return int'(v);
    endfunction

    // Mostly uniform grey levels, with black and white forced now and then.
    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 35;
        endcase
    endfunction

    // All-white source gives all-white quads: the averages cannot lose anything.
    function automatic zoom_quad_t white_quad(input int x, input int y, input logic last);
        zoom_quad_t q;
        q = '{COORD_W'(x), COORD_W'(y), 8'hFF, 8'hFF, 8'hFF, 8'hFF, last};
        return q;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR: %s", msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want, input zoom_quad_t at);
        if (got !== want)
        begin
            flag_error($sformatf("%s of quad (%0d,%0d): got %0h, want %0h",
                                 name, at.x, at.y, got, want));
        end
    endtask

    // Advance the predictor by one source pixel; hit tells whether it closes a quad.
    task automatic zoom_step(input logic [PIX_W-1:0] pix, input logic start,
                             output bit hit, output zoom_quad_t q);
        int w, h, c0, r0, cw, ch, r, c, x, y, ul, ur, lf, d;
        w  = clamp_side(width_reg, MAX_WIDTH);
        h  = clamp_side(height_reg, MAX_HEIGHT);
        c0 = w >> 2;
        r0 = h >> 2;
        cw = w >> 1;
        ch = h >> 1;
        d  = int'(pix);
        hit = 1'b0;
        q   = NO_QUAD;
        if (start)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        r  = int'(row_pos);
        c  = int'(col_pos);
        ul = int'(upper_left_pix);
        ur = 0;
        lf = int'(left_pix);
        // The line store keeps the previous row over crop columns c0 .. c0+cw:
        // read the pixel above, then overwrite it with the current one.
        if (c >= c0 && c - c0 <= cw)
        begin
            ur = int'(prior_row[c - c0]);
            prior_row[c - c0] = pix;
        end
        // The current pixel is the bottom-right corner of the neighborhood.
        if (r > r0 && r <= r0 + ch && c > c0 && c <= c0 + cw)
        begin
            x      = c - c0 - 1;
            y      = r - r0 - 1;
            hit    = 1'b1;
            q.x    = COORD_W'(x);
            q.y    = COORD_W'(y);
            q.tl   = PIX_W'(ul);
            q.tr   = PIX_W'((ul + ur) >> 1);
            q.bl   = PIX_W'((ul + lf) >> 1);
            q.br   = PIX_W'((ul + ur + lf + d) >> 2);
            q.last = (y == ch - 1 && x == cw - 1);
        end
        upper_left_pix = PIX_W'(ur);
        left_pix       = pix;
        if (c >= w - 1)
        begin
            col_pos = '0;
            row_pos = (r >= h - 1) ? '0 : CNT_W'(r + 1);
        end
        else
        begin
            col_pos = CNT_W'(c + 1);
        end
    endtask

    // Offer one pixel transaction and return at the edge that takes it. An idle
    // burst may come first; valid is then dropped for its length.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic start,
                              input logic typed, input logic typed_hit,
                              input zoom_quad_t typed_quad);
        bit         hit;
        zoom_quad_t q;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        zoom_step(pix, start, hit, q);
        if (typed)
        begin
            hit = typed_hit;
            q   = typed_quad;
        end
        if (hit)
        begin
            pending_quads.push_back(q);
        end
        pixel_valid <= 1'b1;
        pixel       <= pix;
        frame_start <= start;
        @(posedge clk);
        while (pixel_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Write both registers once the block has gone quiet: every quad delivered and
    // the pipeline given time to empty.
    task automatic write_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        pixel_valid <= 1'b0;
        while (pending_quads.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= REG_FRAME_WIDTH;
        cfg_wdata        <= w;
        @(posedge clk);
        cfg_index        <= REG_FRAME_HEIGHT;
        cfg_wdata        <= h;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        width_reg  = w;
        height_reg = h;
    endtask

    // Quad sink: check each transaction against the oldest prediction, then pick
    // the stall for the next cycle. A toggle of hold_token starts the long hold-off.
    always @(posedge clk)
    begin : quad_sink
        zoom_quad_t want;
        if (rst_n && quad_valid && !quad_stall)
        begin
            if (pending_quads.size() == 0)
            begin
                flag_error($sformatf("quad (%0d,%0d) with nothing expected", quad_x, quad_y));
            end
            else
            begin
                want = pending_quads.pop_front();
                compare_field("quad_x", 16'(quad_x), 16'(want.x), want);
                compare_field("quad_y", 16'(quad_y), 16'(want.y), want);
                compare_field("top_left", 16'(top_left), 16'(want.tl), want);
                compare_field("top_right", 16'(top_right), 16'(want.tr), want);
                compare_field("bottom_left", 16'(bottom_left), 16'(want.bl), want);
                compare_field("bottom_right", 16'(bottom_right), 16'(want.br), want);
                compare_field("frame_last", 16'(frame_last), 16'(want.last), want);
            end
        end
        if (hold_token != hold_seen)
        begin
            hold_seen  = hold_token;
            stall_left = LONG_HOLD;
        end
        else if (stall_left == 0 && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
        begin
            stall_left = $urandom_range(1, 17);
        end
        quad_stall <= (stall_left != 0);
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
        end
    end

    // Watchdog: any transaction on either channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && !pixel_stall) || (quad_valid && !quad_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("center_crop_bilinear_zoom_2x: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int               random_sent;
        int               phase;
        int               frames;
        int               frame_px;
        int               run_px;
        bit               calm;
        logic             fs;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;

        foreach (prior_row[i])
        begin
            prior_row[i] = '0;
        end

        // Directed table, 4x4 frame: crop origin (1,1), crop 2x2, four quads.
        // The first sixteen rows are a white frame whose quads are known outright.
        // Then the next frame begins by wrap-around, and a frame start lands on the
        // last pixel of its first row to restart the counters.
        directed_rows = '{
            '{8'hFF, 1'b1, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b1, white_quad(0, 0, 1'b0)},
            '{8'hFF, 1'b0, 1'b1, 1'b1, white_quad(1, 0, 1'b0)},
            '{8'hFF, 1'b0, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b0, NO_QUAD},
            '{8'hFF, 1'b0, 1'b1, 1'b1, white_quad(0, 1, 1'b0)},
            '{8'hFF, 1'b0, 1'b1, 1'b1, white_quad(1, 1, 1'b1)},
            '{8'h00, 1'b0, 1'b0, 1'b0, NO_QUAD},
            '{8'h7F, 1'b0, 1'b0, 1'b0, NO_QUAD},
            '{8'h80, 1'b0, 1'b0, 1'b0, NO_QUAD},
            '{8'h01, 1'b1, 1'b0, 1'b0, NO_QUAD},
            '{8'hFE, 1'b0, 1'b0, 1'b0, NO_QUAD},
            '{8'h55, 1'b0, 1'b0, 1'b0, NO_QUAD},
            '{8'hAA, 1'b0, 1'b0, 1'b0, NO_QUAD},
            '{8'h00, 1'b0, 1'b0, 1'b0, NO_QUAD}
        };

        // Hold reset, then release it for good.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Below the minimum: both sides clamp to 4.
        write_geometry(12'd3, 12'd0);
        tx_idle_pct = 20;
        rx_idle_pct <= 20;
        foreach (directed_rows[i])
        begin
            send_pixel(directed_rows[i].pix, directed_rows[i].start, directed_rows[i].typed,
                       directed_rows[i].has_quad, directed_rows[i].quad);
        end

        // Register extremes: large values clamp to 2048 and zero clamps to 4. A short
        // run each stays far above the crop, so no quad may come out.
        tx_idle_pct = 8;
        rx_idle_pct <= 8;
        for (int k = 0; k < 2; k++)
        begin
            case (k)
                0:       write_geometry(12'hFFF, 12'h000);
                default: write_geometry(12'h000, 12'hFFF);
            endcase
            for (int i = 0; i < 16; i++)
            begin
                send_pixel(random_pixel(), i == 0, 1'b0, 1'b0, NO_QUAD);
            end
        end

        // One full 24x4 frame writes line-store entries 0 .. 12. That covers the crop
        // of every geometry the random part can pick, so later geometry changes in
        // mid-frame read only entries already written.
        write_geometry(12'd24, 12'd4);
        for (int i = 0; i < 96; i++)
        begin
            send_pixel(random_pixel(), i == 0, 1'b0, 1'b0, NO_QUAD);
        end

        // Random phases. The first one is the back-pressure phase: 8x8 frames sent
        // without gaps while the sink holds off long enough to back up the input.
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            calm = (random_sent >= RANDOM_ITEMS - CALM_TAIL);
            if (phase == 0)
            begin
                w = 12'd8;
                h = 12'd8;
            end
            else
            begin
                w = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 5))
                                                : CFG_W'($urandom_range(4, 20));
                h = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 5))
                                                : CFG_W'($urandom_range(4, 20));
            end
            write_geometry(w, h);
            tx_idle_pct = (calm || phase == 0) ? 0 : pick_idle();
            rx_idle_pct <= calm ? 0 : pick_idle();
            if (phase == 0)
            begin
                hold_token <= ~hold_token;
            end

            frame_px = clamp_side(w, MAX_WIDTH) * clamp_side(h, MAX_HEIGHT);
            frames   = (phase == 0) ? 2 : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                // Cut some frames short; the next one then starts over in mid-frame.
                run_px = (phase != 0 && $urandom_range(0, 5) == 0)
                         ? $urandom_range(1, frame_px - 1) : frame_px;
                for (int i = 0; i < run_px && random_sent < RANDOM_ITEMS; i++)
                begin
                    // Drop all idling once the calm tail begins.
                    if (!calm && random_sent >= RANDOM_ITEMS - CALM_TAIL)
                    begin
                        calm        = 1'b1;
                        tx_idle_pct = 0;
                        rx_idle_pct <= 0;
                    end
                    // Leave out the frame start now and then: the counters wrap on
                    // their own, or pick up the new geometry in mid-frame.
                    fs = (i == 0) && (phase == 0 || $urandom_range(0, 3) != 0);
                    send_pixel(random_pixel(), fs, 1'b0, 1'b0, NO_QUAD);
                    random_sent++;
                end
            end
            phase++;
        end

        // Drain: wait for the last quad, then watch a little longer for strays.
        pixel_valid <= 1'b0;
        while (pending_quads.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("center_crop_bilinear_zoom_2x: match");
        end
        else
        begin
            $display("center_crop_bilinear_zoom_2x: mismatch");
        end
        $finish;
    end

endmodule

### center_crop_bilinear_zoom_2x.f
design/cczoom_pkg.sv
design/center_crop_bilinear_zoom_2x.sv
tb/sv/center_crop_bilinear_zoom_2x_test.sv
